// ===== design/hufd_pkg.sv =====
// Shared types and sizes of the pre-order Huffman tree loader and decoder.
// Standalone package; every other design file refers to it by scoped names.
package hufd_pkg;

  localparam int MAX_LEAVES  = 256;
  localparam int SYMBOL_BITS = 8;
  localparam int NODE_DEPTH  = 2 * MAX_LEAVES - 1;

  localparam int MODE_W    = 2;
  localparam int IN_SYM_W  = 8;
  localparam int OUT_SYM_W = 8;

  localparam int NODE_W  = $clog2(NODE_DEPTH);
  localparam int NODES_W = $clog2(NODE_DEPTH + 1);
  localparam int LEAF_W  = $clog2(MAX_LEAVES);
  localparam int LCNT_W  = $clog2(MAX_LEAVES + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_SHAPE   = 2'd0,
    MODE_SYMBOL  = 2'd1,
    MODE_MESSAGE = 2'd2
  } mode_e;

  // Child link: internal children carry a node index, leaf children carry
  // their leaf number so the walk never needs a second node lookup.
  typedef struct packed {
    logic              is_leaf;
    logic [NODE_W-1:0] idx;
  } child_t;

  typedef struct packed {
    logic              zero_we;
    logic              one_we;
    logic [NODE_W-1:0] addr;
    child_t            data;
  } node_wr_t;

  typedef struct packed {
    logic                   we;
    logic [LEAF_W-1:0]      addr;
    logic [SYMBOL_BITS-1:0] data;
  } sym_wr_t;

  typedef struct packed {
    logic ready;
    logic root_leaf;
    logic clear;
  } tree_stat_t;

  typedef struct packed {
    logic              valid;
    logic [LEAF_W-1:0] leaf;
  } emit_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              linked0;
  } stk_ent_t;

endpackage

// ===== design/hufd_if.sv =====
// Valid/ready channel interfaces for input items and decoded symbols.
// Depends on hufd_pkg for field widths.
interface hufd_in_if;
  logic                          valid;
  logic                          ready;
  logic [hufd_pkg::MODE_W-1:0]   mode;
  logic                          new_tree;
  logic                          bit_value;
  logic [hufd_pkg::IN_SYM_W-1:0] leaf_symbol;

  modport source (output valid, mode, new_tree, bit_value, leaf_symbol, input ready);
  modport sink   (input valid, mode, new_tree, bit_value, leaf_symbol, output ready);
endinterface

interface hufd_out_if;
  logic                           valid;
  logic                           ready;
  logic [hufd_pkg::OUT_SYM_W-1:0] symbol;

  modport source (output valid, symbol, input ready);
  modport sink   (input valid, symbol, output ready);
endinterface

// ===== design/hufd_builder.sv =====
// Tree builder: shape bits, open-parent stack, build counters, symbol loading.
// Depends on hufd_pkg; drives node table and symbol table writes.
module hufd_builder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  logic [hufd_pkg::MODE_W-1:0]   mode_i,
  input  logic                          new_tree_i,
  input  logic                          bit_value_i,
  input  logic [hufd_pkg::IN_SYM_W-1:0] leaf_symbol_i,
  output hufd_pkg::node_wr_t            node_wr_o,
  output hufd_pkg::sym_wr_t             sym_wr_o,
  output hufd_pkg::tree_stat_t          stat_o
);

  logic [hufd_pkg::NODES_W-1:0] nodes_q, nodes_d, n_e;
  logic [hufd_pkg::LCNT_W-1:0]  leaves_q, leaves_d, l_e;
  logic [hufd_pkg::LCNT_W-1:0]  syms_q, syms_d;
  logic [hufd_pkg::LCNT_W-1:0]  depth_q, depth_d, d_e;
  logic [hufd_pkg::LCNT_W-1:0]  rd_pos;
  hufd_pkg::stk_ent_t           top_q, top_d;
  logic                         root_leaf_q, root_leaf_d;

  // Stack entries below the top live in memory; the top stays in a register.
  hufd_pkg::stk_ent_t           stk_mem [hufd_pkg::MAX_LEAVES];
  hufd_pkg::stk_ent_t           stk_rd_q;
  logic                         push_we;
  logic [hufd_pkg::LEAF_W-1:0]  push_addr;
  hufd_pkg::stk_ent_t           push_data;
  logic [hufd_pkg::LEAF_W-1:0]  rd_addr;

  logic clr, shape_ok, link, internal, sym_ok;

  always_comb begin
    internal = bit_value_i;
    clr      = take_i && (mode_i == hufd_pkg::MODE_SHAPE) && new_tree_i;
    n_e      = clr ? '0 : nodes_q;
    d_e      = clr ? '0 : depth_q;
    l_e      = clr ? '0 : leaves_q;

    shape_ok = take_i && (mode_i == hufd_pkg::MODE_SHAPE)
               && !((n_e != '0) && (d_e == '0))
               && (n_e < hufd_pkg::NODES_W'(hufd_pkg::NODE_DEPTH))
               && !(internal && (d_e >= hufd_pkg::LCNT_W'(hufd_pkg::MAX_LEAVES)))
               && !(!internal && (l_e >= hufd_pkg::LCNT_W'(hufd_pkg::MAX_LEAVES)));
    link     = shape_ok && (n_e != '0);

    node_wr_o.addr         = top_q.node;
    node_wr_o.zero_we      = link && !top_q.linked0;
    node_wr_o.one_we       = link && top_q.linked0;
    node_wr_o.data.is_leaf = !internal;
    node_wr_o.data.idx     = internal ? n_e[hufd_pkg::NODE_W-1:0]
                                      : hufd_pkg::NODE_W'(l_e);

    top_d     = top_q;
    depth_d   = d_e;
    push_we   = 1'b0;
    push_addr = hufd_pkg::LEAF_W'(d_e - hufd_pkg::LCNT_W'(1));
    push_data = '{node: top_q.node, linked0: 1'b1};

    if (link) begin
      if (!top_q.linked0) begin
        if (internal) begin
          // Park the parent below and open the new node on top.
          push_we = 1'b1;
          top_d   = '{node: n_e[hufd_pkg::NODE_W-1:0], linked0: 1'b0};
          depth_d = d_e + hufd_pkg::LCNT_W'(1);
        end else begin
          top_d.linked0 = 1'b1;
        end
      end else begin
        if (internal) begin
          // Parent closes and the new node takes its place.
          top_d = '{node: n_e[hufd_pkg::NODE_W-1:0], linked0: 1'b0};
        end else begin
          top_d   = stk_rd_q;
          depth_d = d_e - hufd_pkg::LCNT_W'(1);
        end
      end
    end else if (shape_ok && internal) begin
      top_d   = '{node: '0, linked0: 1'b0};
      depth_d = hufd_pkg::LCNT_W'(1);
    end

    rd_pos  = depth_d - hufd_pkg::LCNT_W'(2);
    rd_addr = rd_pos[hufd_pkg::LEAF_W-1:0];

    nodes_d     = shape_ok ? n_e + hufd_pkg::NODES_W'(1) : n_e;
    leaves_d    = (shape_ok && !internal) ? l_e + hufd_pkg::LCNT_W'(1) : l_e;
    root_leaf_d = (shape_ok && (n_e == '0)) ? !internal : root_leaf_q;

    sym_ok        = take_i && (mode_i == hufd_pkg::MODE_SYMBOL) && (syms_q < leaves_q);
    syms_d        = clr ? '0 : (sym_ok ? syms_q + hufd_pkg::LCNT_W'(1) : syms_q);
    sym_wr_o.we   = sym_ok;
    sym_wr_o.addr = syms_q[hufd_pkg::LEAF_W-1:0];
    sym_wr_o.data = hufd_pkg::SYMBOL_BITS'(leaf_symbol_i);

    stat_o.ready     = (nodes_q != '0) && (depth_q == '0) && (syms_q == leaves_q);
    stat_o.root_leaf = root_leaf_q;
    stat_o.clear     = clr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q     <= '0;
      leaves_q    <= '0;
      syms_q      <= '0;
      depth_q     <= '0;
      top_q       <= '0;
      root_leaf_q <= 1'b0;
    end else begin
      nodes_q     <= nodes_d;
      leaves_q    <= leaves_d;
      syms_q      <= syms_d;
      depth_q     <= depth_d;
      top_q       <= top_d;
      root_leaf_q <= root_leaf_d;
    end
  end

  // Read the entry that a pop would need next; forward a same-cycle push.
  always_ff @(posedge clk_i) begin
    if (push_we) begin
      stk_mem[push_addr] <= push_data;
    end
    if (push_we && (push_addr == rd_addr)) begin
      stk_rd_q <= push_data;
    end else begin
      stk_rd_q <= stk_mem[rd_addr];
    end
  end

endmodule

// ===== design/hufd_walker.sv =====
// Tree walker: child link tables and the walk pointer, one message bit a cycle while input is taken.
// Depends on hufd_pkg; takes node writes from the builder, issues leaf hits.
module hufd_walker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        take_i,
  input  logic [hufd_pkg::MODE_W-1:0] mode_i,
  input  logic                        bit_value_i,
  input  hufd_pkg::node_wr_t          node_wr_i,
  input  hufd_pkg::tree_stat_t        stat_i,
  output hufd_pkg::emit_req_t         emit_o
);

  hufd_pkg::child_t zero_mem [hufd_pkg::NODE_DEPTH];
  hufd_pkg::child_t one_mem  [hufd_pkg::NODE_DEPTH];
  hufd_pkg::child_t zero_rd_q, one_rd_q, ent;

  logic [hufd_pkg::NODE_W-1:0] walk_q, walk_d;
  logic                        single_q, single_d;
  logic                        msg;

  always_comb begin
    msg      = take_i && (mode_i == hufd_pkg::MODE_MESSAGE) && stat_i.ready;
    ent      = bit_value_i ? one_rd_q : zero_rd_q;
    walk_d   = walk_q;
    single_d = single_q;
    emit_o   = '0;

    if (stat_i.clear) begin
      walk_d   = '0;
      single_d = 1'b0;
    end else if (msg) begin
      if (stat_i.root_leaf) begin
        // One-leaf tree: emit the root symbol once.
        if (!single_q) begin
          emit_o.valid = 1'b1;
          single_d     = 1'b1;
        end
      end else if (ent.is_leaf) begin
        emit_o.valid = 1'b1;
        emit_o.leaf  = ent.idx[hufd_pkg::LEAF_W-1:0];
        walk_d       = '0;
      end else begin
        walk_d = ent.idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q   <= '0;
      single_q <= 1'b0;
    end else begin
      walk_q   <= walk_d;
      single_q <= single_d;
    end
  end

  // Fetch the children of the next walk node every cycle; forward fresh links.
  always_ff @(posedge clk_i) begin
    if (node_wr_i.zero_we) begin
      zero_mem[node_wr_i.addr] <= node_wr_i.data;
    end
    if (node_wr_i.one_we) begin
      one_mem[node_wr_i.addr] <= node_wr_i.data;
    end
    if (node_wr_i.zero_we && (node_wr_i.addr == walk_d)) begin
      zero_rd_q <= node_wr_i.data;
    end else begin
      zero_rd_q <= zero_mem[walk_d];
    end
    if (node_wr_i.one_we && (node_wr_i.addr == walk_d)) begin
      one_rd_q <= node_wr_i.data;
    end else begin
      one_rd_q <= one_mem[walk_d];
    end
  end

endmodule

// ===== design/hufd_sym_out.sv =====
// Symbol table lookup stage and two-entry output queue.
// Depends on hufd_pkg and hufd_out_if; reports room for a new input item.
module hufd_sym_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hufd_pkg::emit_req_t emit_i,
  input  hufd_pkg::sym_wr_t   sym_wr_i,
  hufd_out_if.source          out_o,
  output logic                room_o
);

  logic [hufd_pkg::SYMBOL_BITS-1:0] sym_mem [hufd_pkg::MAX_LEAVES];
  logic [hufd_pkg::SYMBOL_BITS-1:0] sym_rd_q;
  logic                             look_vld_q;

  logic [hufd_pkg::OUT_SYM_W-1:0] fifo_q [2];
  logic                           wr_ptr_q, rd_ptr_q;
  logic [1:0]                     cnt_q, cnt_d, occ;
  logic                           push, pop;

  always_comb begin
    push         = look_vld_q;
    pop          = (cnt_q != 2'd0) && out_o.ready;
    cnt_d        = cnt_q + {1'b0, push} - {1'b0, pop};
    occ          = cnt_q + {1'b0, look_vld_q} - {1'b0, pop};
    room_o       = occ < 2'd2;
    out_o.valid  = cnt_q != 2'd0;
    out_o.symbol = fifo_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (sym_wr_i.we) begin
      sym_mem[sym_wr_i.addr] <= sym_wr_i.data;
    end
    if (emit_i.valid) begin
      sym_rd_q <= sym_mem[emit_i.leaf];
    end
    if (push) begin
      fifo_q[wr_ptr_q] <= hufd_pkg::OUT_SYM_W'(sym_rd_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      look_vld_q <= 1'b0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      cnt_q      <= 2'd0;
    end else begin
      look_vld_q <= emit_i.valid;
      cnt_q      <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

endmodule

// ===== design/huffman_tree_load_and_decode.sv =====
// Huffman decoder fed a pre-order code tree, then message bits.
// Throughput: one transaction per cycle (shape bit, leaf symbol or message bit),
//   while the lookup stage and output queue have room for a result.
// A decoded symbol passes the symbol table read stage, then the output queue.
// Reset: counters, stack depth, walk pointer and queue clear at once; node,
//   stack and symbol memories hold garbage until written, with no clearing pass.
module huffman_tree_load_and_decode (
  input  logic      clk_i,
  input  logic      rst_ni,
  hufd_in_if.sink   in_chan_i,
  hufd_out_if.source out_chan_o
);

  hufd_pkg::node_wr_t   node_wr;
  hufd_pkg::sym_wr_t    sym_wr;
  hufd_pkg::tree_stat_t stat;
  hufd_pkg::emit_req_t  emit;
  logic                 room;
  logic                 take;

  // Accept whenever the lookup stage and queue can absorb a possible result;
  // every item, even one that yields no result, waits while they are full.
  assign in_chan_i.ready = room;
  assign take            = in_chan_i.valid && room;

  // Build: shape bits link children under the open parent on top of the stack; symbol items fill the symbol table.
  hufd_builder u_builder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .mode_i        (in_chan_i.mode),
    .new_tree_i    (in_chan_i.new_tree),
    .bit_value_i   (in_chan_i.bit_value),
    .leaf_symbol_i (in_chan_i.leaf_symbol),
    .node_wr_o     (node_wr),
    .sym_wr_o      (sym_wr),
    .stat_o        (stat)
  );

  // Walk: the current node's children are prefetched, so each message bit
  // resolves in the cycle it arrives and the next fetch address follows.
  hufd_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .mode_i      (in_chan_i.mode),
    .bit_value_i (in_chan_i.bit_value),
    .node_wr_i   (node_wr),
    .stat_i      (stat),
    .emit_o      (emit)
  );

  // Output: look up the leaf's symbol and hold it until the sink takes it.
  hufd_sym_out u_sym_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .emit_i   (emit),
    .sym_wr_i (sym_wr),
    .out_o    (out_chan_o),
    .room_o   (room)
  );

endmodule
